// ===== hdl/ssd_pkg.sv =====
// Shared types and constants of the sound segment detector.
package ssd_pkg;

   // Classification of one frame, carried from the front part to the back part.
   typedef struct packed {
      logic loud;    // either magnitude above threshold
      logic quiet;   // both magnitudes below threshold
   } ssd_class_type;

   localparam int THRESH_BITS   = 31;
   localparam int FIELD_BITS    = 32;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   // Register index, taken from paddr[3:2].
   typedef enum logic [1:0] {
      REG_THRESHOLD  = 2'd0,
      REG_START_HOLD = 2'd1,
      REG_END_HOLD   = 2'd2,
      REG_UNUSED     = 2'd3
   } ssd_reg_type;

   // Phase of the segment tracker.
   typedef enum logic [1:0] {
      PHASE_SEEK   = 2'b01,
      PHASE_ACTIVE = 2'b10
   } ssd_phase_type;

endpackage

// ===== hdl/ssd_front.sv =====
// Front part: takes stereo frames and classifies them against the threshold.
module ssd_front #(
   parameter int SAMPLE_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [SAMPLE_BITS-1:0]        left_sample,
   input  logic [SAMPLE_BITS-1:0]        right_sample,
   input  logic [ssd_pkg::THRESH_BITS-1:0] threshold,
   output logic                          out_valid,
   input  logic                          out_ready,
   output ssd_pkg::ssd_class_type        out_class
);

   localparam int CMP_BITS = (SAMPLE_BITS > ssd_pkg::THRESH_BITS) ?
                             SAMPLE_BITS : ssd_pkg::THRESH_BITS;

   logic                   valid_ff, valid_in;
   ssd_pkg::ssd_class_type class_ff, class_in;
   logic [SAMPLE_BITS-1:0] mag_left, mag_right;
   logic [CMP_BITS-1:0]    cmp_left, cmp_right, cmp_thresh;
   logic                   advance;

   // Exact magnitude: the most negative sample maps to 2^(SAMPLE_BITS-1).
   assign mag_left  = left_sample[SAMPLE_BITS-1]  ? (~left_sample + 1'b1)  : left_sample;
   assign mag_right = right_sample[SAMPLE_BITS-1] ? (~right_sample + 1'b1) : right_sample;

   assign cmp_left   = CMP_BITS'(mag_left);
   assign cmp_right  = CMP_BITS'(mag_right);
   assign cmp_thresh = CMP_BITS'(threshold);

   assign advance  = !valid_ff || out_ready;
   assign in_ready = advance;

   always_comb begin
      valid_in = valid_ff;
      class_in = class_ff;
      if (advance) begin
         valid_in       = in_valid;
         class_in.loud  = (cmp_left > cmp_thresh) || (cmp_right > cmp_thresh);
         class_in.quiet = (cmp_left < cmp_thresh) && (cmp_right < cmp_thresh);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      class_ff <= class_in;
   end

   assign out_valid = valid_ff;
   assign out_class = class_ff;

endmodule

// ===== hdl/ssd_queue.sv =====
// Short queue of classified frames between the front and back parts.
module ssd_queue #(
   parameter int DEPTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   output logic                   push_ready,
   input  ssd_pkg::ssd_class_type push_class,
   output logic                   pop_valid,
   input  logic                   pop_ready,
   output ssd_pkg::ssd_class_type pop_class
);

   localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(DEPTH + 1);

   ssd_pkg::ssd_class_type mem [DEPTH];
   logic [PTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic                   do_push, do_pop;

   assign push_ready = (count_ff != COUNT_BITS'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_class  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_class;
      end
   end

endmodule

// ===== hdl/ssd_back.sv =====
// Back part: tracks segment state per classified frame and holds the result.
module ssd_back #(
   parameter int INDEX_BITS = 32,
   parameter int HOLD_BITS  = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  ssd_pkg::ssd_class_type in_class,
   input  logic [HOLD_BITS-1:0]   start_hold,
   input  logic [HOLD_BITS-1:0]   end_hold,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [ssd_pkg::FIELD_BITS-1:0] out_start,
   output logic [ssd_pkg::FIELD_BITS-1:0] out_end
);

   localparam int FB = ssd_pkg::FIELD_BITS;

   ssd_pkg::ssd_phase_type phase_ff, phase_in;
   logic [HOLD_BITS:0]     run_ff, run_in;
   logic [INDEX_BITS-1:0]  index_ff, index_in;
   logic [INDEX_BITS-1:0]  cand_start_ff, cand_start_in;
   logic [INDEX_BITS-1:0]  seg_begin_ff, seg_begin_in;
   logic [INDEX_BITS-1:0]  cand_end_ff, cand_end_in;
   logic                   out_valid_ff, out_valid_in;
   logic [FB-1:0]          out_start_ff, out_start_in;
   logic [FB-1:0]          out_end_ff, out_end_in;
   logic [HOLD_BITS:0]     run_next;
   logic [INDEX_BITS+FB-1:0] begin_ext, end_ext;
   logic                   take;

   assign in_ready  = !out_valid_ff || out_ready;
   assign take      = in_valid && in_ready;
   assign run_next  = run_ff + 1'b1;
   assign begin_ext = {{FB{1'b0}}, seg_begin_ff};
   assign end_ext   = {{FB{1'b0}}, cand_end_ff};

   always_comb begin
      phase_in      = phase_ff;
      run_in        = run_ff;
      index_in      = index_ff;
      cand_start_in = cand_start_ff;
      seg_begin_in  = seg_begin_ff;
      cand_end_in   = cand_end_ff;
      out_valid_in  = out_valid_ff && !out_ready;
      out_start_in  = out_start_ff;
      out_end_in    = out_end_ff;
      if (take) begin
         index_in = index_ff + 1'b1;
         unique case (phase_ff)
            ssd_pkg::PHASE_SEEK: begin
               if (in_class.loud) begin
                  run_in = run_next;
                  if (run_next > {1'b0, start_hold}) begin
                     seg_begin_in = cand_start_ff;
                     cand_end_in  = index_ff;
                     phase_in     = ssd_pkg::PHASE_ACTIVE;
                     run_in       = '0;
                  end
               end else begin
                  run_in        = '0;
                  cand_start_in = index_ff;
               end
            end
            ssd_pkg::PHASE_ACTIVE: begin
               if (in_class.quiet) begin
                  run_in = run_next;
                  if (run_next > {1'b0, end_hold}) begin
                     // close the segment and emit its bounds
                     out_valid_in  = 1'b1;
                     out_start_in  = begin_ext[FB-1:0];
                     out_end_in    = end_ext[FB-1:0];
                     phase_in      = ssd_pkg::PHASE_SEEK;
                     run_in        = '0;
                     cand_start_in = index_ff;
                  end
               end else begin
                  run_in      = '0;
                  cand_end_in = index_ff;
               end
            end
            default: begin
               phase_in = ssd_pkg::PHASE_SEEK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= ssd_pkg::PHASE_SEEK;
         run_ff        <= '0;
         index_ff      <= '0;
         cand_start_ff <= '0;
         seg_begin_ff  <= '0;
         cand_end_ff   <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         run_ff        <= run_in;
         index_ff      <= index_in;
         cand_start_ff <= cand_start_in;
         seg_begin_ff  <= seg_begin_in;
         cand_end_ff   <= cand_end_in;
         out_valid_ff  <= out_valid_in;
      end
      out_start_ff <= out_start_in;
      out_end_ff   <= out_end_in;
   end

   assign out_valid = out_valid_ff;
   assign out_start = out_start_ff;
   assign out_end   = out_end_ff;

endmodule

// ===== hdl/sound_segment_detector.sv =====
// Top level of the sound segment detector: register port and channel wiring.
//
// Usage: each transfer on the req_ channel is one stereo frame. A front stage
// computes both channel magnitudes and compares them with the threshold; the
// classified frame goes through a four-entry queue to a back stage that counts
// loud and quiet runs, tracks the frame index and opens and closes segments.
// When a segment closes, one transfer on rsp_ carries its start and end index.
// Frames that close no segment give no rsp_ transfer.
// Throughput: one frame per clock cycle while the rsp_ side is not stalled.
// The frame that closes a segment passes the front-stage register, a queue
// entry and the back-stage state update before rsp_tvalid rises.
// A stalled rsp_ side holds its result in the output register; the queue then
// absorbs up to four frames plus one in the front stage before req_tready drops.
// Reset sets seek phase, zeroes the other tracking state, index and registers.
// Registers (csr_, APB): threshold at 0x0, start_hold at 0x4, end_hold at 0x8;
// write them only while no frame is in flight.
module sound_segment_detector #(
   parameter int SAMPLE_BITS = 32,
   parameter int INDEX_BITS  = 32,
   parameter int HOLD_BITS   = 24
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // left_sample [SAMPLE_BITS-1:0], right_sample above it, zero padded to bytes
   input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // segment_start [31:0], segment_end [63:32]
   output logic [2*ssd_pkg::FIELD_BITS-1:0] rsp_tdata,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [ssd_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [ssd_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [ssd_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic csr_pready
);

   localparam int REQ_BITS = ((2*SAMPLE_BITS+7)/8)*8;

   logic [ssd_pkg::THRESH_BITS-1:0] threshold_ff, threshold_in;
   logic [HOLD_BITS-1:0]            start_hold_ff, start_hold_in;
   logic [HOLD_BITS-1:0]            end_hold_ff, end_hold_in;
   ssd_pkg::ssd_reg_type            reg_sel;
   logic                            csr_write;

   logic                   front_valid, front_ready;
   ssd_pkg::ssd_class_type front_class;
   logic                   queue_valid, queue_ready;
   ssd_pkg::ssd_class_type queue_class;
   logic [REQ_BITS-1:0]    req_bits;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel    = ssd_pkg::ssd_reg_type'(csr_paddr[3:2]);

   always_comb begin
      threshold_in  = threshold_ff;
      start_hold_in = start_hold_ff;
      end_hold_in   = end_hold_ff;
      if (csr_write) begin
         unique case (reg_sel)
            ssd_pkg::REG_THRESHOLD:  threshold_in  = csr_pwdata[ssd_pkg::THRESH_BITS-1:0];
            ssd_pkg::REG_START_HOLD: start_hold_in = csr_pwdata[HOLD_BITS-1:0];
            ssd_pkg::REG_END_HOLD:   end_hold_in   = csr_pwdata[HOLD_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         ssd_pkg::REG_THRESHOLD:  csr_prdata = ssd_pkg::CSR_DATA_BITS'(threshold_ff);
         ssd_pkg::REG_START_HOLD: csr_prdata = ssd_pkg::CSR_DATA_BITS'(start_hold_ff);
         ssd_pkg::REG_END_HOLD:   csr_prdata = ssd_pkg::CSR_DATA_BITS'(end_hold_ff);
         default:                 csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff  <= '0;
         start_hold_ff <= '0;
         end_hold_ff   <= '0;
      end else begin
         threshold_ff  <= threshold_in;
         start_hold_ff <= start_hold_in;
         end_hold_ff   <= end_hold_in;
      end
   end

   assign req_bits = req_tdata;

   ssd_front #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .left_sample  (req_bits[SAMPLE_BITS-1:0]),
      .right_sample (req_bits[2*SAMPLE_BITS-1:SAMPLE_BITS]),
      .threshold    (threshold_ff),
      .out_valid    (front_valid),
      .out_ready    (front_ready),
      .out_class    (front_class)
   );

   ssd_queue #(
      .DEPTH (4)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_class (front_class),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_class  (queue_class)
   );

   ssd_back #(
      .INDEX_BITS (INDEX_BITS),
      .HOLD_BITS  (HOLD_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (queue_valid),
      .in_ready   (queue_ready),
      .in_class   (queue_class),
      .start_hold (start_hold_ff),
      .end_hold   (end_hold_ff),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_start  (rsp_tdata[ssd_pkg::FIELD_BITS-1:0]),
      .out_end    (rsp_tdata[2*ssd_pkg::FIELD_BITS-1:ssd_pkg::FIELD_BITS])
   );

endmodule

// ===== dv/sound_segment_detector_test.sv =====
// Self-checking testbench for the sound segment detector: streamed frames, APB setup.
`timescale 1ns / 100ps

module sound_segment_detector_test;

   localparam int MOST_NEG = 32'sh80000000;
   localparam int MOST_POS = 32'sh7FFFFFFF;
   localparam logic [30:0] THRESH_MAX = 31'h7FFFFFFF;
   localparam logic [23:0] HOLD_MAX = 24'hFFFFFF;
   localparam int SETTLE_CYCLES = 16;

   // one closed segment, packed as on rsp_tdata
   typedef struct packed {
      logic [31:0] last;
      logic [31:0] first;
   } segment_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [63:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [ssd_pkg::CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [ssd_pkg::CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [ssd_pkg::CSR_DATA_BITS-1:0] csr_prdata;
   logic csr_pready;

   // register copies
   logic [30:0] thr_cfg = '0;
   logic [23:0] start_hold_cfg = '0;
   logic [23:0] end_hold_cfg = '0;

   // segment tracker state
   logic in_seg = 1'b0;
   logic [24:0] run_len = '0;
   logic [31:0] frame_idx = '0;
   logic [31:0] cand_start = '0;
   logic [31:0] seg_begin = '0;
   logic [31:0] cand_end = '0;

   logic [63:0] pending_frames[$];
   segment_type segments_due[$];
   int frames_pushed = 0;
   int frames_offered = 0;
   int frames_accepted = 0;
   int error_count = 0;
   bit steady = 1'b0;

   sound_segment_detector DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),     // left_sample [31:0], right_sample [63:32]
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),     // segment_start [31:0], segment_end [63:32]
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(string what);
      $display("ERROR at %0t ns: %s", $time, what);
      error_count++;
   endtask

   function automatic logic [32:0] magnitude_of(logic [31:0] s);
      return s[31] ? (~{1'b1, s}) + 33'd1 : {1'b0, s};
   endfunction

   task automatic track_frame(logic [31:0] left, logic [31:0] right);
      logic [32:0] ml;
      logic [32:0] mr;
      logic [32:0] thr;
      logic loud;
      logic quiet;
      ml = magnitude_of(left);
      mr = magnitude_of(right);
      thr = {2'b00, thr_cfg};
      loud = (ml > thr) || (mr > thr);
      quiet = (ml < thr) && (mr < thr);
      if (!in_seg) begin
         if (loud) begin
            run_len++;
            if (run_len > start_hold_cfg) begin
               // the opening frame is loud, so it is the first end candidate
               seg_begin = cand_start;
               cand_end = frame_idx;
               in_seg = 1'b1;
               run_len = '0;
            end
         end else begin
            run_len = '0;
            cand_start = frame_idx;
         end
      end else if (quiet) begin
         run_len++;
         if (run_len > end_hold_cfg) begin
            segments_due.push_back({cand_end, seg_begin});
            in_seg = 1'b0;
            run_len = '0;
            cand_start = frame_idx;
         end
      end else begin
         run_len = '0;
         cand_end = frame_idx;
      end
      frame_idx++;
   endtask

   // sender: hold a frame until its transfer, then offer the next one
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!(req_tvalid && frames_accepted != frames_offered)) begin
         if (pending_frames.size() != 0 && (steady || $urandom_range(99) >= 13)) begin
            req_tdata <= pending_frames.pop_front();
            req_tvalid <= 1'b1;
            frames_offered++;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_tready <= steady || $urandom_range(99) >= 13;
   end

   always @(posedge clock) begin
      segment_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (segments_due.size() == 0) begin
               report_mismatch($sformatf("unexpected result %h", rsp_tdata));
            end else begin
               want = segments_due.pop_front();
               if (rsp_tdata[31:0] !== want.first)
                  report_mismatch($sformatf("segment_start %h, want %h",
                                            rsp_tdata[31:0], want.first));
               if (rsp_tdata[63:32] !== want.last)
                  report_mismatch($sformatf("segment_end %h, want %h",
                                            rsp_tdata[63:32], want.last));
            end
         end
         if (req_tvalid && req_tready) begin
            track_frame(req_tdata[31:0], req_tdata[63:32]);
            frames_accepted++;
         end
      end
   end

   task automatic push_frame(int left, int right);
      pending_frames.push_back({right, left});
      frames_pushed++;
   endtask

   // pause until every frame went through and every result came out
   task automatic wait_drained();
      while (frames_accepted != frames_pushed || segments_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(ssd_pkg::ssd_reg_type idx, logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         ssd_pkg::REG_THRESHOLD:  thr_cfg = value[30:0];
         ssd_pkg::REG_START_HOLD: start_hold_cfg = value[23:0];
         ssd_pkg::REG_END_HOLD:   end_hold_cfg = value[23:0];
         default: ;
      endcase
   endtask

   task automatic configure(logic [30:0] thr, logic [23:0] start_hold, logic [23:0] end_hold);
      wait_drained();
      write_reg(ssd_pkg::REG_THRESHOLD, {1'b0, thr});
      write_reg(ssd_pkg::REG_START_HOLD, {8'd0, start_hold});
      write_reg(ssd_pkg::REG_END_HOLD, {8'd0, end_hold});
   endtask

   // a sample whose magnitude exceeds thr, often just above it
   function automatic logic [31:0] sample_above(logic [30:0] thr);
      logic [32:0] span;
      logic [32:0] offset;
      logic [32:0] mag;
      span = 33'h080000000 - {2'b00, thr};
      offset = $urandom_range(1) ? 33'($urandom_range(3)) : 33'($urandom) % span;
      if (offset >= span) offset = span - 1;
      mag = {2'b00, thr} + 33'd1 + offset;
      if (mag == 33'h080000000) return 32'h80000000;
      return $urandom_range(1) ? -mag[31:0] : mag[31:0];
   endfunction

   // a sample whose magnitude is below thr; none exists for a zero threshold
   function automatic logic [31:0] sample_below(logic [30:0] thr);
      logic [31:0] mag;
      if (thr == 0) return '0;
      if ($urandom_range(1)) begin
         mag = {1'b0, thr} - 32'd1;
         mag = mag - ((mag < 3) ? mag : 32'($urandom_range(3)));
      end else begin
         mag = $urandom % {1'b0, thr};
      end
      return $urandom_range(1) ? -mag : mag;
   endfunction

   function automatic int run_length(logic [23:0] hold);
      if (hold > 40) return $urandom_range(1, 8);
      if (hold != 0 && $urandom_range(4) == 0) return hold;
      return hold + 1 + $urandom_range(2);
   endfunction

   task automatic push_run(bit loud, int len);
      logic [31:0] edge_val;
      for (int i = 0; i < len; i++) begin
         edge_val = $urandom_range(1) ? {1'b0, thr_cfg} : -{1'b0, thr_cfg};
         if ($urandom_range(19) == 0)
            // magnitude equal to threshold: neither loud nor quiet, breaks the run
            push_frame(edge_val, sample_below(thr_cfg));
         else if (!loud)
            push_frame(sample_below(thr_cfg), sample_below(thr_cfg));
         else
            case ($urandom_range(2))
               0: push_frame(sample_above(thr_cfg), $urandom);
               1: push_frame($urandom, sample_above(thr_cfg));
               default: push_frame(sample_above(thr_cfg), sample_above(thr_cfg));
            endcase
      end
   endtask

   initial begin
      int phase_no;
      int target;
      logic [30:0] thr;
      logic [23:0] holds[2];

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // single-frame runs; first segment starts at index zero, most negative samples
      configure(31'd1000, 24'd0, 24'd0);
      push_frame(2000, 0);
      push_frame(0, 0);
      push_frame(MOST_NEG, 0);
      push_frame(1000, -1000);
      push_frame(-999, 999);
      push_frame(1000, 1000);
      push_frame(MOST_POS, MOST_NEG);
      push_frame(0, -1001);
      push_frame(-1, 1);
      push_frame(32'sh55555555, 32'shAAAAAAAA);
      push_frame(32'shAAAAAAAA, 32'sh55555555);
      push_frame(0, 0);

      // zero threshold: nothing is quiet, an open segment stays open
      configure(31'd0, 24'd2, 24'd1);
      push_frame(0, 0);
      push_frame(1, 0);
      push_frame(0, -1);
      push_frame(MOST_NEG, MOST_POS);
      push_frame(0, 0);
      push_frame(0, 0);

      configure(THRESH_MAX, HOLD_MAX, HOLD_MAX);
      push_frame(MOST_NEG, MOST_NEG);
      push_frame(MOST_POS, 0);
      push_frame(0, 0);

      configure(THRESH_MAX, 24'd0, 24'd0);
      push_frame(0, 0);
      push_frame(0, MOST_NEG);
      push_frame(MOST_POS, -MOST_POS);
      push_frame(5, 5);

      phase_no = 0;
      while (frames_pushed < 1100) begin
         case ($urandom_range(9))
            0: thr = 31'($urandom);
            1: thr = THRESH_MAX;
            2: thr = 31'd1;
            default: thr = 31'($urandom_range(2, 1 << 20));
         endcase
         foreach (holds[k])
            case ($urandom_range(9))
               0: holds[k] = HOLD_MAX;
               1, 2: holds[k] = 24'($urandom_range(6, 40));
               default: holds[k] = 24'($urandom_range(5));
            endcase
         configure(thr, holds[0], holds[1]);
         steady = (phase_no == 2);
         target = frames_pushed + $urandom_range(60, 150);
         while (frames_pushed < target) begin
            if ($urandom_range(9) < 8) begin
               push_run(1'b1, run_length(start_hold_cfg));
               push_run(1'b0, run_length(end_hold_cfg));
            end else begin
               repeat ($urandom_range(1, 4)) push_frame($urandom, $urandom);
            end
         end
         phase_no++;
      end

      wait_drained();
      if (error_count == 0)
         $display("sound_segment_detector_test passed");
      else
         $display("sound_segment_detector_test failed");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("sound_segment_detector_test failed");
      $finish;
   end

endmodule
